@@ design/fsif_pkg.sv @@
// Shared types, character codes and a lookup function for the integer formatter.
// Used by the controller, the datapath and the top level.
package fsif_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned NUM_DIGITS     = 20;
  localparam int unsigned DIGIT_IDX_W    = 5;
  localparam int unsigned ARG_W          = 64;
  localparam int unsigned CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_IS_64 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_IS_64 = 1'd1;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_PCT  = "%";
  localparam logic [7:0] CH_MIN  = "-";
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_X    = "x";
  localparam logic [7:0] CH_BIGX = "X";
  localparam logic [7:0] CH_LOWL = "l";
  localparam logic [7:0] CH_BIGL = "L";
  localparam logic [7:0] CH_H    = "h";
  localparam logic [7:0] CH_Z    = "z";
  localparam logic [7:0] CH_D    = "d";
  localparam logic [7:0] CH_I    = "i";
  localparam logic [7:0] CH_U    = "u";
  localparam logic [7:0] CH_P    = "p";
  localparam logic [7:0] CH_C    = "c";

  typedef struct packed {
    logic [7:0]       format_char;
    logic [ARG_W-1:0] argument;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        last;
    logic        string_done;
    logic [15:0] written_count;
  } out_beat_t;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_PCT    = 3'd1,
    PH_GOT_L  = 3'd2,
    PH_GOT_H  = 3'd3,
    PH_CONV   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    MOD_NONE = 3'd0,
    MOD_L    = 3'd1,
    MOD_LL   = 3'd2,
    MOD_H    = 3'd3,
    MOD_HH   = 3'd4,
    MOD_BIGL = 3'd5,
    MOD_Z    = 3'd6
  } modifier_e;

  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2,
    W64 = 2'd3
  } width_e;

  typedef enum logic [2:0] {
    EM_ECHO    = 3'd0,
    EM_LOWBYTE = 3'd1,
    EM_PCT     = 3'd2,
    EM_MINUS   = 3'd3,
    EM_ZERO    = 3'd4,
    EM_X       = 3'd5,
    EM_DIGIT   = 3'd6,
    EM_TERM    = 3'd7
  } emit_sel_e;

  typedef struct packed {
    logic      load;
    logic      conv_load;
    logic      conv_signed;
    logic      conv_hex;
    width_e    conv_width;
    logic      dab_step;
    logic      dig_skip;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic [7:0] format_char;
    logic       conv_done;
    logic       neg;
    logic       skip;
    logic       last_digit;
    logic       out_free;
  } dp_status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'h0: c = "0";
      4'h1: c = "1";
      4'h2: c = "2";
      4'h3: c = "3";
      4'h4: c = "4";
      4'h5: c = "5";
      4'h6: c = "6";
      4'h7: c = "7";
      4'h8: c = "8";
      4'h9: c = "9";
      4'ha: c = "a";
      4'hb: c = "b";
      4'hc: c = "c";
      4'hd: c = "d";
      4'he: c = "e";
      default: c = "f";
    endcase
    return c;
  endfunction

endpackage

@@ design/fsif_ctrl.sv @@
// Controller: parse state, conversion sequencing and result ordering.
// Depends on fsif_pkg; drives the datapath through ctl_cmd_t.
module fsif_ctrl import fsif_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i,
  input  dp_status_t           status_i,
  output ctl_cmd_t             cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_CONV   = 7'b0000100,
    S_MINUS  = 7'b0001000,
    S_P0     = 7'b0010000,
    S_P1     = 7'b0100000,
    S_DIGITS = 7'b1000000
  } state_e;

  state_e    state_q, state_d;
  phase_e    phase_q, phase_d;
  modifier_e mod_q, mod_d;
  logic      ptr_q, ptr_d;
  logic      long64_q, size64_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long64_q <= 1'b0;
      size64_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_LONG_IS_64) long64_q <= cfg_data_i;
      if (cfg_index_i == CFG_SIZE_IS_64) size64_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_NORMAL;
      mod_q   <= MOD_NONE;
      ptr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      mod_q   <= mod_d;
      ptr_q   <= ptr_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  logic [7:0] ch;
  logic       is_conv;
  modifier_e  conv_mod;

  assign ch = status_i.format_char;

  always_comb begin
    is_conv  = 1'b0;
    conv_mod = MOD_NONE;
    case (phase_q)
      PH_PCT: begin
        is_conv = (ch != CH_LOWL) && (ch != CH_H) && (ch != CH_BIGL) && (ch != CH_Z);
      end
      PH_GOT_L: begin
        is_conv  = (ch != CH_LOWL);
        conv_mod = MOD_L;
      end
      PH_GOT_H: begin
        is_conv  = (ch != CH_H);
        conv_mod = MOD_H;
      end
      PH_CONV: begin
        is_conv  = 1'b1;
        conv_mod = mod_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    mod_d   = mod_q;
    ptr_d   = ptr_q;
    cmd_o   = '0;
    cmd_o.conv_width = W32;
    cmd_o.emit_sel   = EM_ECHO;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (ch == CH_NUL) begin
          if (status_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_sel  = EM_TERM;
            cmd_o.emit_last = 1'b1;
            phase_d = PH_NORMAL;
            mod_d   = MOD_NONE;
            state_d = S_IDLE;
          end
        end else if (phase_q == PH_NORMAL) begin
          if (ch == CH_PCT) begin
            phase_d = PH_PCT;
            state_d = S_IDLE;
          end else if (status_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_sel  = EM_ECHO;
            cmd_o.emit_last = 1'b1;
            state_d = S_IDLE;
          end
        end else if (!is_conv) begin
          // modifier byte: advance parse phase only
          state_d = S_IDLE;
          case (phase_q)
            PH_PCT: begin
              mod_d = MOD_NONE;
              if (ch == CH_LOWL) phase_d = PH_GOT_L;
              else if (ch == CH_H) phase_d = PH_GOT_H;
              else if (ch == CH_BIGL) begin
                mod_d   = MOD_BIGL;
                phase_d = PH_CONV;
              end else begin
                mod_d   = MOD_Z;
                phase_d = PH_CONV;
              end
            end
            PH_GOT_L: begin
              mod_d   = MOD_LL;
              phase_d = PH_CONV;
            end
            default: begin
              mod_d   = MOD_HH;
              phase_d = PH_CONV;
            end
          endcase
        end else begin
          case (ch)
            CH_D, CH_I, CH_U, CH_X, CH_BIGX, CH_P: begin
              cmd_o.conv_load   = 1'b1;
              cmd_o.conv_signed = (ch == CH_D) || (ch == CH_I);
              cmd_o.conv_hex    = (ch == CH_X) || (ch == CH_BIGX) || (ch == CH_P);
              if (conv_mod == MOD_LL) cmd_o.conv_width = W64;
              else if (conv_mod == MOD_L) cmd_o.conv_width = long64_q ? W64 : W32;
              else if (ch == CH_U && conv_mod == MOD_Z) begin
                cmd_o.conv_width = size64_q ? W64 : W32;
              end else if (ch != CH_U && conv_mod == MOD_HH) cmd_o.conv_width = W8;
              else if (ch != CH_U && conv_mod == MOD_H) cmd_o.conv_width = W16;
              else cmd_o.conv_width = W32;
              if (cmd_o.conv_hex) cmd_o.conv_width = W32;
              ptr_d   = (ch == CH_P);
              phase_d = PH_NORMAL;
              mod_d   = MOD_NONE;
              state_d = S_CONV;
            end
            CH_C, CH_PCT: begin
              if (status_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_sel  = (ch == CH_C) ? EM_LOWBYTE : EM_PCT;
                cmd_o.emit_last = 1'b1;
                phase_d = PH_NORMAL;
                mod_d   = MOD_NONE;
                state_d = S_IDLE;
              end
            end
            default: begin
              // unsupported letter: consume silently
              phase_d = PH_NORMAL;
              mod_d   = MOD_NONE;
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CONV: begin
        if (!status_i.conv_done) cmd_o.dab_step = 1'b1;
        else if (status_i.neg) state_d = S_MINUS;
        else if (ptr_q) state_d = S_P0;
        else state_d = S_DIGITS;
      end
      S_MINUS: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EM_MINUS;
          state_d        = S_DIGITS;
        end
      end
      S_P0: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EM_ZERO;
          state_d        = S_P1;
        end
      end
      S_P1: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EM_X;
          state_d        = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (status_i.skip) cmd_o.dig_skip = 1'b1;
        else if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EM_DIGIT;
          cmd_o.emit_last = status_i.last_digit;
          if (status_i.last_digit) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.emit |-> status_i.out_free)
    else $error("result issued while output register is occupied");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("controller state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.load |=> state_q == S_DECODE)
    else $error("accepted beat not decoded next cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_o.dab_step |-> (state_q == S_CONV) && !status_i.conv_done)
    else $error("conversion step outside conversion");

endmodule

@@ design/fsif_dp.sv @@
// Datapath: input latch, magnitude prep, shift-add decimal conversion, digit
// store, byte counter and output register. Depends on fsif_pkg.
module fsif_dp import fsif_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_beat_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_beat_t  out_data_o,
  input  ctl_cmd_t   cmd_i,
  output dp_status_t status_o
);

  localparam int unsigned ExtW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int unsigned StepW = $clog2(ARG_W);

  logic [7:0]             char_q;
  logic [ARG_W-1:0]       arg_q;
  logic [ARG_W-1:0]       val_q, val_d;
  logic                   neg_q;
  logic                   done_q;
  logic [StepW-1:0]       step_q;
  logic [3:0]             dig_q [NUM_DIGITS];
  logic [3:0]             dig_d [NUM_DIGITS];
  logic [3:0]             adj   [NUM_DIGITS];
  logic [DIGIT_IDX_W-1:0] rem_q;
  logic [DIGIT_IDX_W-1:0] idx;
  logic                   started_q;
  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic                   out_valid_q;
  out_beat_t              out_q;

  // sign-extend per width and take the magnitude
  logic [ARG_W-1:0] sext;
  logic             sign;
  always_comb begin
    case (cmd_i.conv_width)
      W8:      sext = {{(ARG_W-8){arg_q[7]}}, arg_q[7:0]};
      W16:     sext = {{(ARG_W-16){arg_q[15]}}, arg_q[15:0]};
      W32:     sext = {{(ARG_W-32){arg_q[31]}}, arg_q[31:0]};
      default: sext = arg_q;
    endcase
    sign = cmd_i.conv_signed && sext[ARG_W-1];
    if (sign) val_d = '0 - sext;
    else begin
      case (cmd_i.conv_width)
        W8:      val_d = {{(ARG_W-8){1'b0}}, arg_q[7:0]};
        W16:     val_d = {{(ARG_W-16){1'b0}}, arg_q[15:0]};
        W32:     val_d = {{(ARG_W-32){1'b0}}, arg_q[31:0]};
        default: val_d = arg_q;
      endcase
    end
  end

  // one shift-add-3 step over all digit lanes
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
    end
    dig_d[0] = {adj[0][2:0], val_q[ARG_W-1]};
    for (int i = 1; i < NUM_DIGITS; i++) begin
      dig_d[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  assign idx = rem_q - DIGIT_IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= in_data_i.format_char;
      arg_q  <= in_data_i.argument;
    end
    if (cmd_i.conv_load) begin
      val_q  <= val_d;
      neg_q  <= sign;
      step_q <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        if (cmd_i.conv_hex && i < 8) dig_q[i] <= val_d[4*i +: 4];
        else dig_q[i] <= 4'd0;
      end
    end else if (cmd_i.dab_step) begin
      val_q  <= val_q << 1;
      step_q <= step_q + StepW'(1);
      for (int i = 0; i < NUM_DIGITS; i++) dig_q[i] <= dig_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      rem_q     <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.conv_load) begin
      done_q    <= cmd_i.conv_hex;
      rem_q     <= cmd_i.conv_hex ? DIGIT_IDX_W'(8) : DIGIT_IDX_W'(NUM_DIGITS);
      started_q <= 1'b0;
    end else begin
      if (cmd_i.dab_step && step_q == {StepW{1'b1}}) done_q <= 1'b1;
      if (cmd_i.dig_skip) rem_q <= idx;
      if (cmd_i.emit && cmd_i.emit_sel == EM_DIGIT) begin
        rem_q     <= idx;
        started_q <= 1'b1;
      end
    end
  end

  // saturating byte count; terminator shows it and then clears it
  logic [ExtW-1:0] count_ext;
  logic [7:0]      emit_char;
  always_comb begin
    count_d = count_q;
    if (cmd_i.emit && cmd_i.emit_sel != EM_TERM && count_q != {COUNT_BITS{1'b1}}) begin
      count_d = count_q + COUNT_BITS'(1);
    end
    count_ext = ExtW'(count_d);
    case (cmd_i.emit_sel)
      EM_ECHO:    emit_char = char_q;
      EM_LOWBYTE: emit_char = arg_q[7:0];
      EM_PCT:     emit_char = CH_PCT;
      EM_MINUS:   emit_char = CH_MIN;
      EM_ZERO:    emit_char = CH_ZERO;
      EM_X:       emit_char = CH_X;
      EM_DIGIT:   emit_char = hex_char(dig_q[idx]);
      default:    emit_char = CH_NUL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        count_q     <= (cmd_i.emit_sel == EM_TERM) ? '0 : count_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.out_char      <= emit_char;
      out_q.last          <= cmd_i.emit_last;
      out_q.string_done   <= (cmd_i.emit_sel == EM_TERM);
      out_q.written_count <= (count_ext > ExtW'(16'hFFFF)) ? 16'hFFFF : count_ext[15:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.format_char = char_q;
  assign status_o.conv_done   = done_q;
  assign status_o.neg         = neg_q;
  assign status_o.skip        = !started_q && (dig_q[idx] == 4'd0) &&
                                (rem_q != DIGIT_IDX_W'(1));
  assign status_o.last_digit  = (rem_q == DIGIT_IDX_W'(1));
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

@@ design/format_string_integer_formatter_core.sv @@
// Top level of the integer formatter: controller plus datapath.
// Depends on fsif_pkg, fsif_ctrl and fsif_dp.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_stall_o   in_beat_t  (format_char, argument)
//   out      output     out_valid_o/out_stall_i out_beat_t (out_char, last, ...)
//   cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// One format byte is taken per beat; the next is taken once all its results are issued.
// Plain bytes are echoed directly; hex walks 8 digit slots (each emitted or skipped),
// %p emits a 0x prefix first; decimal first runs 64 shift-add-3 steps and walks 20
// digit slots, after a minus sign for a negative value.
// Reset clears parse state, count and configuration; the digit store is not reset.
// A stalled result holds in the output register and the sequence waits behind it.
module format_string_integer_formatter_core import fsif_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  fsif_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fsif_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
